/* hdl/pnu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnu_pkg
// Shared types and constants for the packed normal unpack unit.
// ----------------------------------------------------------------------------
package pnu_pkg;

   typedef enum logic [1:0] {
      LAYOUT_11_11_10 = 2'd0,
      LAYOUT_11_10_11 = 2'd1,
      LAYOUT_10_11_11 = 2'd2,
      LAYOUT_SPARE    = 2'd3
   } layout_type;

   localparam int FIELD_W = 11;
   localparam int FLOAT_W = 32;
   localparam int EXP_BIAS = 127;

   // Fixed-point image of the quotient: one integer bit, then five periods
   // of the repeating fraction.
   localparam int VEC_W = 51;

   typedef struct packed {
      logic [FIELD_W-1:0] raw;  // field bits, right aligned
      logic               wide; // 1: 11-bit field, 0: 10-bit field
   } field_type;

endpackage
`default_nettype wire

/* hdl/pnu_field_conv.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnu_field_conv
// Converts one signed 10- or 11-bit field to binary32 of n/511 or n/1023.
// ----------------------------------------------------------------------------
module pnu_field_conv (
   input  var pnu_pkg::field_type           field,
   output logic [pnu_pkg::FLOAT_W-1:0]      result
);

   logic        neg;
   logic [10:0] mag;
   logic [10:0] div;
   logic        int_bit;
   logic [9:0]  rem;
   logic [pnu_pkg::VEC_W-1:0] vec;
   logic [pnu_pkg::VEC_W-1:0] vec_sh;
   logic [3:0]  lz;
   logic        found;
   logic [22:0] mant;
   logic        guard;
   logic [24:0] sig;
   logic [7:0]  expo;

   // x / (2^k - 1) = a + b/(2^k - 1), and b/(2^k - 1) is b repeated every k
   // bits, so the fraction never terminates unless b is zero: no ties occur.
   always_comb begin
      neg = field.wide ? field.raw[10] : field.raw[9];
      if (field.wide) begin
         div = 11'd1023;
         mag = neg ? (11'd1024 - {1'b0, field.raw[9:0]}) : {1'b0, field.raw[9:0]};
      end else begin
         div = 11'd511;
         mag = neg ? (11'd512 - {2'b00, field.raw[8:0]}) : {2'b00, field.raw[8:0]};
      end
      int_bit = (mag >= div);
      rem     = int_bit ? 10'(mag - div) : mag[9:0];
      if (field.wide)
         vec = {int_bit, {5{rem[9:0]}}};
      else
         vec = {int_bit, {5{rem[8:0]}}, 5'b0};

      lz    = '0;
      found = 1'b0;
      for (int i = 0; i < 11; i++) begin
         if (!found && vec[pnu_pkg::VEC_W-1-i]) begin
            lz    = 4'(i);
            found = 1'b1;
         end
      end

      vec_sh = vec << lz;
      mant   = vec_sh[pnu_pkg::VEC_W-2 -: 23];
      guard  = vec_sh[pnu_pkg::VEC_W-25];
      sig    = {2'b01, mant} + {24'd0, guard};
      expo   = 8'(pnu_pkg::EXP_BIAS) - {4'd0, lz};
      if (sig[24]) begin
         expo = expo + 8'd1;
         mant = '0;
      end else begin
         mant = sig[22:0];
      end

      if (mag == '0)
         result = '0;
      else
         result = {neg, expo, mant};
   end

endmodule
`default_nettype wire

/* hdl/packed_normal_unpack_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// packed_normal_unpack_unit
// Splits a packed 32-bit normal into three signed fields as binary32 values.
// ----------------------------------------------------------------------------
// One item per clock: busy is always low, so start may be held high every
// cycle. Each item is registered in the input register, then in the result
// register, before its result shows on rsp_valid; the receiver cannot stall
// and the result is shown for one cycle only. The layout register is written
// through csr_valid/csr_ready, is always ready, and should be changed only
// when no item is in flight.
module packed_normal_unpack_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [31:0] req_packed_normal,
   output logic        rsp_valid,
   output logic [31:0] rsp_x_component,
   output logic [31:0] rsp_y_component,
   output logic [31:0] rsp_z_component,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_field_layout
);

   pnu_pkg::layout_type layout_ff;
   logic                s1_valid_ff;
   logic [31:0]         s1_word_ff;
   pnu_pkg::layout_type s1_layout_ff;
   pnu_pkg::field_type  fx, fy, fz;
   logic [31:0]         x_in, y_in, z_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff   <= pnu_pkg::LAYOUT_11_11_10;
         s1_valid_ff <= 1'b0;
         rsp_valid   <= 1'b0;
      end else begin
         if (csr_valid)
            layout_ff <= pnu_pkg::layout_type'(csr_field_layout);
         s1_valid_ff <= start;
         rsp_valid   <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_word_ff      <= req_packed_normal;
      s1_layout_ff    <= layout_ff;
      rsp_x_component <= x_in;
      rsp_y_component <= y_in;
      rsp_z_component <= z_in;
   end

   always_comb begin
      unique case (s1_layout_ff)
         pnu_pkg::LAYOUT_11_10_11: begin
            fx = '{raw: s1_word_ff[31:21], wide: 1'b1};
            fy = '{raw: {1'b0, s1_word_ff[20:11]}, wide: 1'b0};
            fz = '{raw: s1_word_ff[10:0], wide: 1'b1};
         end
         pnu_pkg::LAYOUT_10_11_11: begin
            fx = '{raw: {1'b0, s1_word_ff[31:22]}, wide: 1'b0};
            fy = '{raw: s1_word_ff[21:11], wide: 1'b1};
            fz = '{raw: s1_word_ff[10:0], wide: 1'b1};
         end
         default: begin
            fx = '{raw: s1_word_ff[31:21], wide: 1'b1};
            fy = '{raw: s1_word_ff[20:10], wide: 1'b1};
            fz = '{raw: {1'b0, s1_word_ff[9:0]}, wide: 1'b0};
         end
      endcase
   end

   pnu_field_conv u_conv_x (.field(fx), .result(x_in));
   pnu_field_conv u_conv_y (.field(fy), .result(y_in));
   pnu_field_conv u_conv_z (.field(fz), .result(z_in));

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |=> ##1 rsp_valid) else $error("item lost in pipeline");
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 2)) else $error("result without item");
   a_zero_word: assert property (@(posedge clock) disable iff (reset)
      start && req_packed_normal == 32'd0 |=> ##1
      (rsp_x_component == 32'd0 && rsp_y_component == 32'd0
       && rsp_z_component == 32'd0)) else $error("zero word not +0");

endmodule
`default_nettype wire

/* test/tb_packed_normal_unpack_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packed_normal_unpack_unit
// Drives packed normals through the unpack unit under each layout, checks
// every result against an integer model of the scaled binary32 components.
// ----------------------------------------------------------------------------
module tb_packed_normal_unpack_unit;

   localparam int LIMIT_CYCLES = 400000;
   localparam int RANDOM_ITEMS = 1100;
   localparam int SETTLE       = 8;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } normal_type;

   typedef struct {
      logic [31:0] word;
      logic        typed;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_packed_normal = '0;
   logic        rsp_valid;
   logic [31:0] rsp_x_component;
   logic [31:0] rsp_y_component;
   logic [31:0] rsp_z_component;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_field_layout = '0;

   pnu_pkg::layout_type cur_layout = pnu_pkg::LAYOUT_11_11_10;
   normal_type  pending_normals[$];
   int          errors = 0;
   int          cycles = 0;
   int          accepted = 0;
   int          idle_pct = 0;

   packed_normal_unpack_unit u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_packed_normal(req_packed_normal),
      .rsp_valid(rsp_valid), .rsp_x_component(rsp_x_component),
      .rsp_y_component(rsp_y_component), .rsp_z_component(rsp_z_component),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_field_layout(csr_field_layout)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("packed_normal_unpack_unit verification failed");
         $finish;
      end
   end

   // (neg ? -mag : mag) / div rounded to nearest even, as binary32 bits
   function automatic logic [31:0] quotient_bits(bit neg, int unsigned mag,
                                                 int unsigned div);
      longint unsigned num, q, r;
      int unsigned     k;
      k = 0;
      if (mag == 0) return 32'h0;
      num = mag;
      while (k < 40 && (num << k) < (longint'(div) << 23)) k++;
      q = (num << k) / div;
      r = (num << k) % div;
      if (2 * r > div || (2 * r == div && q[0])) q++;
      if (q >= (64'd1 << 24)) begin
         q = q >> 1;
         k--;
      end
      return {neg, 8'(150 - k), q[22:0]};
   endfunction

   function automatic logic [31:0] field_bits(logic [31:0] raw, int unsigned width);
      int unsigned half, low, p;
      half = 1 << (width - 1);
      low  = half - 1;
      p    = raw & ((1 << width) - 1);
      if (p & half) return quotient_bits(1'b1, half - (p & low), low);
      return quotient_bits(1'b0, p, low);
   endfunction

   function automatic normal_type unpack_normal(logic [31:0] w,
                                                pnu_pkg::layout_type lay);
      normal_type  n;
      int unsigned w1, w2, w3;
      w1 = 11; w2 = 11; w3 = 10;
      if (lay == pnu_pkg::LAYOUT_11_10_11) begin
         w2 = 10; w3 = 11;
      end else if (lay == pnu_pkg::LAYOUT_10_11_11) begin
         w1 = 10; w3 = 11;
      end
      n.x = field_bits(w >> (w2 + w3), w1);
      n.y = field_bits(w >> w3, w2);
      n.z = field_bits(w, w3);
      return n;
   endfunction

   always @(posedge clock) begin
      normal_type e;
      if (!reset && rsp_valid) begin
         if (pending_normals.size() == 0) begin
            $error("result with nothing expected");
            errors++;
         end else begin
            e = pending_normals.pop_front();
            if (rsp_x_component !== e.x) begin
               $error("x_component exp %h got %h", e.x, rsp_x_component); errors++;
            end
            if (rsp_y_component !== e.y) begin
               $error("y_component exp %h got %h", e.y, rsp_y_component); errors++;
            end
            if (rsp_z_component !== e.z) begin
               $error("z_component exp %h got %h", e.z, rsp_z_component); errors++;
            end
         end
      end
   end

   // one item; typed rows also cross-check the predictor
   task automatic send_item(row_type row);
      normal_type n;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      n = unpack_normal(row.word, cur_layout);
      if (row.typed && (n.x !== row.x || n.y !== row.y || n.z !== row.z)) begin
         $error("table row %h: predictor %h %h %h", row.word, n.x, n.y, n.z);
         errors++;
         n.x = row.x; n.y = row.y; n.z = row.z;
      end
      start <= 1'b1;
      req_packed_normal <= row.word;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_normals.push_back(n);
      accepted++;
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_normals.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_layout(pnu_pkg::layout_type lay);
      csr_valid <= 1'b1;
      csr_field_layout <= lay;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_layout = (lay == pnu_pkg::LAYOUT_SPARE) ? pnu_pkg::LAYOUT_11_11_10 : lay;
      @(posedge clock);
   endtask

   row_type directed[$];

   initial begin
      row_type             r;
      pnu_pkg::layout_type lays[4];
      int                  idles[4];
      lays  = '{pnu_pkg::LAYOUT_11_10_11, pnu_pkg::LAYOUT_10_11_11,
                pnu_pkg::LAYOUT_SPARE, pnu_pkg::LAYOUT_11_11_10};
      idles = '{0, 83, 0, 33};
      // zero, full-scale, most negative codes, all ones, mixed bits
      directed.push_back('{32'h0000_0000, 1, 32'h0, 32'h0, 32'h0});
      directed.push_back('{32'h7FEF_FDFF, 1, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000});
      directed.push_back('{32'h8010_0200, 0, 0, 0, 0});
      directed.push_back('{32'hFFFF_FFFF, 0, 0, 0, 0});
      directed.push_back('{32'h0020_0401, 0, 0, 0, 0});
      directed.push_back('{32'hAAAA_AAAA, 0, 0, 0, 0});
      directed.push_back('{32'h5555_5555, 0, 0, 0, 0});
      directed.push_back('{32'h0010_0000, 0, 0, 0, 0});
      directed.push_back('{32'h8000_0000, 0, 0, 0, 0});

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_item(directed[i]);
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         write_layout(lays[ph]);
         idle_pct = idles[ph];
         foreach (directed[i]) begin
            r = directed[i];
            r.typed = 1'b0;
            send_item(r);
         end
         for (int i = 0; i < RANDOM_ITEMS / 4; i++) begin
            r.typed = 1'b0;
            case ($urandom_range(3))
               0: r.word = $urandom() | (32'h1 << $urandom_range(31));
               1: r.word = $urandom() & ~(32'h1 << $urandom_range(31));
               default: r.word = $urandom();
            endcase
            send_item(r);
         end
         drain();
      end

      $display("Covered %0d items over all four layout codes, idling 0..83 percent.",
               accepted);
      if (errors == 0) begin
         $display("packed_normal_unpack_unit verification clean");
      end else begin
         $display("packed_normal_unpack_unit verification failed");
      end
      $finish;
   end

endmodule
